@@ hw/rtl/drr_pkg.sv @@
// ----------------------------------------------------------------------------
// drr_pkg - shared types and constants of the disc region rasterizer
// Holds the box descriptor passed from front to back, the configuration
// bundle and the register index codes.
// ----------------------------------------------------------------------------
package drr_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS    = 2'd0;
  localparam logic [1:0] CFG_CELL_SIZE = 2'd1;
  localparam logic [1:0] CFG_GRID_W    = 2'd2;
  localparam logic [1:0] CFG_GRID_H    = 2'd3;

  // numerators are 26-bit signed, six divisions per centre
  localparam int DIV_BITS = 26;
  localparam int NUM_DIV  = 6;

  // sqrt: 26 result bits, two per cycle
  localparam int SQRT_CYCLES = 13;

  typedef struct packed {
    logic [23:0] radius;
    logic [15:0] cell_size;   // zero already replaced by one
    logic [15:0] grid_w;
    logic [15:0] grid_h;
  } drr_cfg_t;

  typedef struct packed {
    logic               box_ok;
    logic [15:0]        ix0;
    logic [15:0]        ix1;
    logic [15:0]        iy0;
    logic [15:0]        iy1;
    logic [31:0]        px0;
    logic [31:0]        py0;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic               rep_ok;
    logic [15:0]        rep_x;
    logic [15:0]        rep_y;
  } drr_desc_t;

  // clamp a cell index to [0, g-1]
  function automatic logic [15:0] clamp_cell(input logic signed [27:0] q,
                                             input logic [15:0] g);
    logic [15:0] res;
    if (q < 0) begin
      res = 16'd0;
    end else if (q >= $signed({12'd0, g})) begin
      res = g - 16'd1;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/disc_region_rasterizer.sv @@
// ----------------------------------------------------------------------------
// disc_region_rasterizer - grid cells covered by a disc
// Takes disc centres and emits the grid cells within the configured radius.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per disc centre (signed Q16.8 x and y), valid/ready.
//   out_* : one beat per covered cell, x outer, y inner; the final beat of a
//           centre has out_last_cell set. A centre may give no beat at all.
//   cfg_* : write radius, cell size and grid size while the block is idle.
// Operation:
//   Box setup runs six divisions (load, 26 steps, round) on one shared
//   restoring divider, then clamp, cut and push. The scan walks the columns
//   and the rows of each column in range; a cell in range is squared and
//   summed, and one inside the disc passes the square root unit before it is
//   emitted. A two-entry queue lets the next centre's setup overlap the scan.
// Reset:
//   Synchronous active-low reset empties queue and output register and
//   loads radius 256, cell size 256 and a 256 x 256 grid.
// Stall:
//   in_ready is low during setup and stays low while the queue is full, until
//   the scan frees an entry. Beats wait on out_ready while out_valid is set.
// ----------------------------------------------------------------------------
module disc_region_rasterizer #(
  parameter int BOX_SPAN = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_center_x,
  input  logic signed [23:0] in_center_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_cell_x,
  output logic [15:0]        out_cell_y,
  output logic [23:0]        out_distance,
  output logic               out_in_area,
  output logic               out_in_border,
  output logic               out_last_cell
);

  logic [23:0] radius_r;
  logic [15:0] cell_size_r, grid_w_r, grid_h_r;
  drr_pkg::drr_cfg_t  cfg;
  drr_pkg::drr_desc_t push_data, pop_data;
  logic push, full, pop, not_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 24'd256;
      cell_size_r <= 16'd256;
      grid_w_r    <= 16'd256;
      grid_h_r    <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        drr_pkg::CFG_RADIUS:    radius_r    <= cfg_wdata;
        drr_pkg::CFG_CELL_SIZE: cell_size_r <= cfg_wdata[15:0];
        drr_pkg::CFG_GRID_W:    grid_w_r    <= cfg_wdata[15:0];
        drr_pkg::CFG_GRID_H:    grid_h_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // zero cell size acts as one
  always_comb begin
    cfg.radius    = radius_r;
    cfg.cell_size = (cell_size_r == 16'd0) ? 16'd1 : cell_size_r;
    cfg.grid_w    = grid_w_r;
    cfg.grid_h    = grid_h_r;
  end

  drr_front #(.BOX_SPAN(BOX_SPAN)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .q_push      (push),
    .q_data      (push_data),
    .q_full      (full)
  );

  drr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  drr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_not_empty   (not_empty),
    .q_data        (pop_data),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_distance  (out_distance),
    .out_in_area   (out_in_area),
    .out_in_border (out_in_border),
    .out_last_cell (out_last_cell)
  );

endmodule

@@ hw/rtl/drr_front.sv @@
// ----------------------------------------------------------------------------
// drr_front - centre intake and bounding box setup
// Runs six round-half-even divisions on a shared restoring divider, clamps
// and cuts the box, and pushes one descriptor per centre to the queue.
// ----------------------------------------------------------------------------
module drr_front #(
  parameter int BOX_SPAN = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  drr_pkg::drr_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  in_center_x,
  input  logic signed [23:0]  in_center_y,
  output logic                q_push,
  output drr_pkg::drr_desc_t  q_data,
  input  logic                q_full
);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_LOAD = 7'b0000010,
    F_DIV  = 7'b0000100,
    F_RND  = 7'b0001000,
    F_CLMP = 7'b0010000,
    F_CUT  = 7'b0100000,
    F_PUSH = 7'b1000000
  } front_state_t;

  localparam logic [16:0] SPAN_M1 = 17'(BOX_SPAN - 1);

  front_state_t state_r, state_nxt;
  logic signed [23:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [25:0] quo_r, quo_nxt;
  logic signed [27:0] q_r [drr_pkg::NUM_DIV];
  logic signed [27:0] q_fin;
  logic [15:0] x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  drr_pkg::drr_desc_t desc_r, desc_nxt;

  logic signed [25:0] num;
  logic [16:0] rem_sh;
  logic signed [27:0] q_base;
  logic [15:0] rem_adj;
  logic [16:0] rem2;
  logic        round_up;
  logic [16:0] xlim, ylim;

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = desc_r;

  // pick the numerator of division k
  always_comb begin
    case (k_r)
      3'd0:    num = 26'(cx_r) - $signed({2'b0, cfg.radius});
      3'd1:    num = 26'(cx_r) + $signed({2'b0, cfg.radius});
      3'd2:    num = 26'(cy_r) - $signed({2'b0, cfg.radius});
      3'd3:    num = 26'(cy_r) + $signed({2'b0, cfg.radius});
      3'd4:    num = 26'(cx_r);
      default: num = 26'(cy_r);
    endcase
  end

  // restoring divide step and round-half-even fixup
  always_comb begin
    rem_sh   = {rem_r, quo_r[25]};
    if (neg_r && rem_r != 16'd0) begin
      q_base  = -$signed({2'b0, quo_r}) - 28'sd1;
      rem_adj = cfg.cell_size - rem_r;
    end else if (neg_r) begin
      q_base  = -$signed({2'b0, quo_r});
      rem_adj = rem_r;
    end else begin
      q_base  = $signed({2'b0, quo_r});
      rem_adj = rem_r;
    end
    rem2     = {rem_adj, 1'b0};
    round_up = (rem2 > {1'b0, cfg.cell_size}) ||
               ((rem2 == {1'b0, cfg.cell_size}) && q_base[0]);
    q_fin    = q_base + $signed({27'd0, round_up});
    xlim     = {1'b0, x0_r} + SPAN_M1;
    ylim     = {1'b0, y0_r} + SPAN_M1;
  end

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    x0_nxt    = x0_r;
    x1_nxt    = x1_r;
    y0_nxt    = y0_r;
    y1_nxt    = y1_r;
    desc_nxt  = desc_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          cx_nxt    = in_center_x;
          cy_nxt    = in_center_y;
          k_nxt     = 3'd0;
          state_nxt = F_LOAD;
        end
      end
      F_LOAD: begin
        neg_nxt   = num[25];
        quo_nxt   = num[25] ? 26'(-num) : 26'(num);
        rem_nxt   = 16'd0;
        cnt_nxt   = 5'd0;
        state_nxt = F_DIV;
      end
      F_DIV: begin
        if (rem_sh >= {1'b0, cfg.cell_size}) begin
          rem_nxt = 16'(rem_sh - {1'b0, cfg.cell_size});
          quo_nxt = {quo_r[24:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[15:0];
          quo_nxt = {quo_r[24:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(drr_pkg::DIV_BITS - 1)) begin
          state_nxt = F_RND;
        end
      end
      F_RND: begin
        if (k_r == 3'(drr_pkg::NUM_DIV - 1)) begin
          state_nxt = F_CLMP;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = F_LOAD;
        end
      end
      F_CLMP: begin
        x0_nxt          = drr_pkg::clamp_cell(q_r[0], cfg.grid_w);
        x1_nxt          = drr_pkg::clamp_cell(q_r[1], cfg.grid_w);
        y0_nxt          = drr_pkg::clamp_cell(q_r[2], cfg.grid_h);
        y1_nxt          = drr_pkg::clamp_cell(q_r[3], cfg.grid_h);
        desc_nxt.box_ok = (cfg.grid_w != 16'd0) && (cfg.grid_h != 16'd0);
        desc_nxt.rep_ok = (q_r[4] >= 0) && (q_r[4] < $signed({12'd0, cfg.grid_w})) &&
                          (q_r[5] >= 0) && (q_r[5] < $signed({12'd0, cfg.grid_h}));
        desc_nxt.rep_x  = q_r[4][15:0];
        desc_nxt.rep_y  = q_r[5][15:0];
        desc_nxt.cx     = cx_r;
        desc_nxt.cy     = cy_r;
        state_nxt       = F_CUT;
      end
      F_CUT: begin
        desc_nxt.ix0 = x0_r;
        desc_nxt.iy0 = y0_r;
        desc_nxt.ix1 = ({1'b0, x1_r} > xlim) ? xlim[15:0] : x1_r;
        desc_nxt.iy1 = ({1'b0, y1_r} > ylim) ? ylim[15:0] : y1_r;
        desc_nxt.px0 = x0_r * cfg.cell_size;
        desc_nxt.py0 = y0_r * cfg.cell_size;
        state_nxt    = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    x0_r   <= x0_nxt;
    x1_r   <= x1_nxt;
    y0_r   <= y0_nxt;
    y1_r   <= y1_nxt;
    desc_r <= desc_nxt;
    // store the rounded quotient of division k
    if (state_r == F_RND) begin
      q_r[k_r] <= q_fin;
    end
  end

endmodule

@@ hw/rtl/drr_queue.sv @@
// ----------------------------------------------------------------------------
// drr_queue - two-entry descriptor queue
// Decouples box setup from the cell scan.
// ----------------------------------------------------------------------------
module drr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  drr_pkg::drr_desc_t push_data,
  output logic               full,
  input  logic               pop,
  output drr_pkg::drr_desc_t pop_data,
  output logic               not_empty
);

  drr_pkg::drr_desc_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  // advance pointers and count
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop  ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/drr_back.sv @@
// ----------------------------------------------------------------------------
// drr_back - cell scan and result emission
// Walks the box x outer, y inner, tests each cell against the disc, takes
// the integer square root of the squared distance and emits results, holding
// one back so the final beat of a centre carries last_cell.
// ----------------------------------------------------------------------------
module drr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  drr_pkg::drr_cfg_t  cfg,
  input  logic               q_not_empty,
  input  drr_pkg::drr_desc_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_cell_x,
  output logic [15:0]        out_cell_y,
  output logic [23:0]        out_distance,
  output logic               out_in_area,
  output logic               out_in_border,
  output logic               out_last_cell
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_XCOL = 9'b000000010,
    B_YROW = 9'b000000100,
    B_MUL  = 9'b000001000,
    B_SUM  = 9'b000010000,
    B_SQRT = 9'b000100000,
    B_PUT  = 9'b001000000,
    B_FIN  = 9'b010000000,
    B_REP  = 9'b100000000
  } back_state_t;

  back_state_t state_r, state_nxt;
  drr_pkg::drr_desc_t desc_r, desc_nxt;
  logic [15:0] ix_r, ix_nxt, iy_r, iy_nxt;
  logic [31:0] px_r, px_nxt, py_r, py_nxt;
  logic [23:0] dxm_r, dxm_nxt, dym_r, dym_nxt;
  logic [47:0] sx_r, sy_r;
  logic [51:0] sqv_r, sqv_nxt;
  logic [27:0] sqrem_r, sqrem_nxt;
  logic [25:0] sqroot_r, sqroot_nxt;
  logic [3:0]  sqcnt_r, sqcnt_nxt;
  logic        border_r, border_nxt;
  logic        any_area_r, any_area_nxt, any_border_r, any_border_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [15:0] pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [23:0] pend_d_r, pend_d_nxt;
  logic        pend_b_r, pend_b_nxt;
  logic [47:0] r2_r, t2_r;
  logic        tpos_r;
  logic signed [24:0] t_val;

  logic        ov_r, ov_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [23:0] od_r, od_nxt;
  logic        oa_r, oa_nxt, ob_r, ob_nxt, ol_r, ol_nxt;

  logic        out_free;
  logic signed [33:0] dx, dy, rs;
  logic        dx_in, dy_in;
  logic [48:0] d2;
  logic        row_last, col_last;
  back_state_t rowadv_state, coladv_state;
  logic [15:0] rowadv_ix, rowadv_iy, coladv_ix;
  logic [31:0] rowadv_px, rowadv_py, coladv_px;
  logic [51:0] sv;
  logic [27:0] srem, strial;
  logic [25:0] sroot;

  assign out_valid     = ov_r;
  assign out_cell_x    = ox_r;
  assign out_cell_y    = oy_r;
  assign out_distance  = od_r;
  assign out_in_area   = oa_r;
  assign out_in_border = ob_r;
  assign out_last_cell = ol_r;
  assign out_free      = !ov_r || out_ready;
  assign q_pop         = (state_r == B_IDLE) && q_not_empty;

  // offsets of the current column and row from the centre
  always_comb begin
    rs       = $signed({10'd0, cfg.radius});
    dx       = $signed({2'b0, px_r}) - 34'(desc_r.cx);
    dy       = $signed({2'b0, py_r}) - 34'(desc_r.cy);
    dx_in    = (dx >= -rs) && (dx <= rs);
    dy_in    = (dy >= -rs) && (dy <= rs);
    d2       = {1'b0, sx_r} + {1'b0, sy_r};
    row_last = (iy_r == desc_r.iy1);
    col_last = (ix_r == desc_r.ix1);
    t_val    = $signed({1'b0, cfg.radius}) - $signed({9'd0, cfg.cell_size});
  end

  // next position after the current column or row
  always_comb begin
    coladv_ix = ix_r + 16'd1;
    coladv_px = px_r + {16'd0, cfg.cell_size};
    coladv_state = col_last ? B_FIN : B_XCOL;
    rowadv_ix = ix_r;
    rowadv_px = px_r;
    rowadv_iy = iy_r;
    rowadv_py = py_r;
    if (row_last) begin
      rowadv_state = coladv_state;
      if (!col_last) begin
        rowadv_ix = coladv_ix;
        rowadv_px = coladv_px;
      end
    end else begin
      rowadv_state = B_YROW;
      rowadv_iy    = iy_r + 16'd1;
      rowadv_py    = py_r + {16'd0, cfg.cell_size};
    end
  end

  // two digit steps of the integer square root
  always_comb begin
    sv    = sqv_r;
    srem  = sqrem_r;
    sroot = sqroot_r;
    for (int i = 0; i < 2; i++) begin
      srem   = {srem[25:0], sv[51:50]};
      strial = {sroot, 2'b01};
      sv     = {sv[49:0], 2'b00};
      if (srem >= strial) begin
        srem  = srem - strial;
        sroot = {sroot[24:0], 1'b1};
      end else begin
        sroot = {sroot[24:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    desc_nxt       = desc_r;
    ix_nxt         = ix_r;
    iy_nxt         = iy_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    dxm_nxt        = dxm_r;
    dym_nxt        = dym_r;
    sqv_nxt        = sqv_r;
    sqrem_nxt      = sqrem_r;
    sqroot_nxt     = sqroot_r;
    sqcnt_nxt      = sqcnt_r;
    border_nxt     = border_r;
    any_area_nxt   = any_area_r;
    any_border_nxt = any_border_r;
    pend_v_nxt     = pend_v_r;
    pend_x_nxt     = pend_x_r;
    pend_y_nxt     = pend_y_r;
    pend_d_nxt     = pend_d_r;
    pend_b_nxt     = pend_b_r;
    ov_nxt         = out_ready ? 1'b0 : ov_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    od_nxt         = od_r;
    oa_nxt         = oa_r;
    ob_nxt         = ob_r;
    ol_nxt         = ol_r;
    case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          desc_nxt       = q_data;
          ix_nxt         = q_data.ix0;
          px_nxt         = q_data.px0;
          any_area_nxt   = 1'b0;
          any_border_nxt = 1'b0;
          pend_v_nxt     = 1'b0;
          state_nxt      = q_data.box_ok ? B_XCOL : B_FIN;
        end
      end
      B_XCOL: begin
        if (dx_in) begin
          dxm_nxt   = dx[33] ? 24'(-dx) : dx[23:0];
          iy_nxt    = desc_r.iy0;
          py_nxt    = desc_r.py0;
          state_nxt = B_YROW;
        end else begin
          ix_nxt    = col_last ? ix_r : coladv_ix;
          px_nxt    = col_last ? px_r : coladv_px;
          state_nxt = coladv_state;
        end
      end
      B_YROW: begin
        if (dy_in) begin
          dym_nxt   = dy[33] ? 24'(-dy) : dy[23:0];
          state_nxt = B_MUL;
        end else begin
          ix_nxt    = rowadv_ix;
          px_nxt    = rowadv_px;
          iy_nxt    = rowadv_iy;
          py_nxt    = rowadv_py;
          state_nxt = rowadv_state;
        end
      end
      B_MUL: begin
        state_nxt = B_SUM;
      end
      B_SUM: begin
        if (d2 > {1'b0, r2_r}) begin
          ix_nxt    = rowadv_ix;
          px_nxt    = rowadv_px;
          iy_nxt    = rowadv_iy;
          py_nxt    = rowadv_py;
          state_nxt = rowadv_state;
        end else begin
          border_nxt = !tpos_r || (d2 >= {1'b0, t2_r});
          sqv_nxt    = {3'd0, d2};
          sqrem_nxt  = 28'd0;
          sqroot_nxt = 26'd0;
          sqcnt_nxt  = 4'd0;
          state_nxt  = B_SQRT;
        end
      end
      B_SQRT: begin
        sqv_nxt    = sv;
        sqrem_nxt  = srem;
        sqroot_nxt = sroot;
        sqcnt_nxt  = sqcnt_r + 4'd1;
        if (sqcnt_r == 4'(drr_pkg::SQRT_CYCLES - 1)) begin
          state_nxt = B_PUT;
        end
      end
      B_PUT: begin
        // flush the held cell first, then hold the new one
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            ov_nxt = 1'b1;
            ox_nxt = pend_x_r;
            oy_nxt = pend_y_r;
            od_nxt = pend_d_r;
            oa_nxt = 1'b1;
            ob_nxt = pend_b_r;
            ol_nxt = 1'b0;
          end
          pend_v_nxt     = 1'b1;
          pend_x_nxt     = ix_r;
          pend_y_nxt     = iy_r;
          pend_d_nxt     = sqroot_r[23:0];
          pend_b_nxt     = border_r;
          any_area_nxt   = 1'b1;
          any_border_nxt = any_border_r || border_r;
          ix_nxt         = rowadv_ix;
          px_nxt         = rowadv_px;
          iy_nxt         = rowadv_iy;
          py_nxt         = rowadv_py;
          state_nxt      = rowadv_state;
        end
      end
      B_FIN: begin
        if ((!any_area_r || !any_border_r) && desc_r.rep_ok) begin
          if (!pend_v_r) begin
            state_nxt = B_REP;
          end else if (out_free) begin
            ov_nxt     = 1'b1;
            ox_nxt     = pend_x_r;
            oy_nxt     = pend_y_r;
            od_nxt     = pend_d_r;
            oa_nxt     = 1'b1;
            ob_nxt     = pend_b_r;
            ol_nxt     = 1'b0;
            pend_v_nxt = 1'b0;
          end
        end else if (!pend_v_r) begin
          state_nxt = B_IDLE;
        end else if (out_free) begin
          ov_nxt     = 1'b1;
          ox_nxt     = pend_x_r;
          oy_nxt     = pend_y_r;
          od_nxt     = pend_d_r;
          oa_nxt     = 1'b1;
          ob_nxt     = pend_b_r;
          ol_nxt     = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = B_IDLE;
        end
      end
      B_REP: begin
        // centre cell fills a missing area or border
        if (out_free) begin
          ov_nxt    = 1'b1;
          ox_nxt    = desc_r.rep_x;
          oy_nxt    = desc_r.rep_y;
          od_nxt    = 24'd0;
          oa_nxt    = !any_area_r;
          ob_nxt    = 1'b1;
          ol_nxt    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ov_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      pend_v_r <= pend_v_nxt;
    end
    desc_r       <= desc_nxt;
    ix_r         <= ix_nxt;
    iy_r         <= iy_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    dxm_r        <= dxm_nxt;
    dym_r        <= dym_nxt;
    sx_r         <= dxm_r * dxm_r;
    sy_r         <= dym_r * dym_r;
    sqv_r        <= sqv_nxt;
    sqrem_r      <= sqrem_nxt;
    sqroot_r     <= sqroot_nxt;
    sqcnt_r      <= sqcnt_nxt;
    border_r     <= border_nxt;
    any_area_r   <= any_area_nxt;
    any_border_r <= any_border_nxt;
    pend_x_r     <= pend_x_nxt;
    pend_y_r     <= pend_y_nxt;
    pend_d_r     <= pend_d_nxt;
    pend_b_r     <= pend_b_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    od_r         <= od_nxt;
    oa_r         <= oa_nxt;
    ob_r         <= ob_nxt;
    ol_r         <= ol_nxt;
    // squared radius and inner ring radius follow the configuration
    r2_r         <= cfg.radius * cfg.radius;
    tpos_r       <= (t_val > 0);
    t2_r         <= t_val[23:0] * t_val[23:0];
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - disc region rasterizer
// Drives disc centres under several radius, cell size and grid settings,
// predicts every covered cell in a behavioral model and checks each output
// beat in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [23:0] dval;
    logic        area;
    logic        border;
    logic        last;
  } cell_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = drr_pkg::CFG_RADIUS;
  logic [23:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] in_center_x = '0;
  logic signed [23:0] in_center_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_cell_x;
  logic [15:0]        out_cell_y;
  logic [23:0]        out_distance;
  logic               out_in_area;
  logic               out_in_border;
  logic               out_last_cell;

  // shadow copy of the configuration registers
  logic [23:0] radius_q = 24'd256;
  logic [15:0] cell_q   = 16'd256;
  logic [15:0] gw_q     = 16'd256;
  logic [15:0] gh_q     = 16'd256;

  cell_t cells_expected[$];
  int    errors = 0;
  int    send_idle = 36;
  int    recv_idle = 49;

  disc_region_rasterizer dut (.*);

  always #5 clk = ~clk;

  // toggle receiver readiness at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // round half to even of n / d, d > 0
  function automatic longint div_round_even(input longint n, input longint d);
    longint q;
    longint rem;
    q = n / d;
    rem = n - q * d;
    if (rem < 0) begin
      q = q - 1;
      rem = rem + d;
    end
    if (2 * rem > d || (2 * rem == d && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic longint clamp_idx(input longint v, input longint g);
    if (v < 0) return 0;
    if (v > g - 1) return g - 1;
    return v;
  endfunction

  // floor of the square root, bit by bit
  function automatic longint sqrt_floor(input longint v);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // compute the covered cells of one centre and queue them
  function automatic void predict_cells(input logic signed [23:0] px,
                                        input logic signed [23:0] py);
    cell_t  found[$];
    cell_t  c;
    longint cx, cy, r, s, gw, gh, t, r2, t2, dx, dy, d2;
    longint ix0, ix1, iy0, iy1, xx, yy;
    int     n_area, n_border;
    cx = px;
    cy = py;
    r = radius_q;
    s = (cell_q == 0) ? 1 : cell_q;
    gw = gw_q;
    gh = gh_q;
    t = r - s;
    r2 = r * r;
    t2 = (t > 0) ? t * t : 0;
    n_area = 0;
    n_border = 0;
    if (gw > 0 && gh > 0) begin
      ix0 = clamp_idx(div_round_even(cx - r, s), gw);
      iy0 = clamp_idx(div_round_even(cy - r, s), gh);
      ix1 = clamp_idx(div_round_even(cx + r, s), gw);
      iy1 = clamp_idx(div_round_even(cy + r, s), gh);
      if (ix1 > ix0 + 6) ix1 = ix0 + 6;
      if (iy1 > iy0 + 6) iy1 = iy0 + 6;
      for (longint ix = ix0; ix <= ix1; ix++) begin
        dx = ix * s - cx;
        if (dx < -r || dx > r) continue;
        for (longint iy = iy0; iy <= iy1; iy++) begin
          dy = iy * s - cy;
          if (dy < -r || dy > r) continue;
          d2 = dx * dx + dy * dy;
          if (d2 > r2) continue;
          c.cx = ix[15:0];
          c.cy = iy[15:0];
          c.dval = 24'(sqrt_floor(d2));
          c.area = 1'b1;
          c.border = (t <= 0) || (d2 >= t2);
          c.last = 1'b0;
          found = {found, c};
          n_area++;
          if (c.border) n_border++;
        end
      end
    end
    // add the centre cell when area or border came out empty
    if (n_area == 0 || n_border == 0) begin
      xx = div_round_even(cx, s);
      yy = div_round_even(cy, s);
      if (xx >= 0 && xx < gw && yy >= 0 && yy < gh) begin
        c.cx = xx[15:0];
        c.cy = yy[15:0];
        c.dval = '0;
        c.area = (n_area == 0);
        c.border = 1'b1;
        c.last = 1'b0;
        found = {found, c};
      end
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) cells_expected = {cells_expected, found[i]};
  endfunction

  // compare each output beat with the oldest expected cell
  always @(posedge clk) begin
    cell_t e;
    if (rst_n && out_valid && out_ready) begin
      if (cells_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat x=%0d y=%0d", out_cell_x, out_cell_y);
      end else begin
        e = cells_expected.pop_front();
        if (out_cell_x !== e.cx || out_cell_y !== e.cy || out_distance !== e.dval ||
            out_in_area !== e.area || out_in_border !== e.border ||
            out_last_cell !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp x=%0d y=%0d d=%0d a=%b b=%b l=%b",
                     e.cx, e.cy, e.dval, e.area, e.border, e.last,
                     " got x=%0d y=%0d d=%0d a=%b b=%b l=%b",
                     out_cell_x, out_cell_y, out_distance, out_in_area,
                     out_in_border, out_last_cell);
        end
      end
    end
  end

  // send one centre; valid stays high across back-to-back beats
  task automatic send_centre(input logic signed [23:0] x, input logic signed [23:0] y);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_center_x <= x;
    in_center_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cells(x, y);
  endtask

  // drop valid, let expected cells drain, then cover silent centres in flight
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (cells_expected.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] r, input logic [15:0] s,
                            input logic [15:0] w, input logic [15:0] h);
    logic [1:0]  idx [4];
    logic [23:0] val [4];
    idx = '{drr_pkg::CFG_RADIUS, drr_pkg::CFG_CELL_SIZE, drr_pkg::CFG_GRID_W,
            drr_pkg::CFG_GRID_H};
    val = '{r, {8'd0, s}, {8'd0, w}, {8'd0, h}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    radius_q = r;
    cell_q = s;
    gw_q = w;
    gh_q = h;
  endtask

  // reset defaults: origin, rounding ties, extremes, centres off the grid
  task automatic test_defaults;
    send_centre(24'sd0, 24'sd0);
    send_centre(24'sd128, 24'sd384);
    send_centre(24'sd640, 24'sd896);
    send_centre(24'sd5000, 24'sd7000);
    send_centre(24'sh7FFFFF, 24'sh7FFFFF);
    send_centre(-24'sh800000, -24'sh800000);
    send_centre(-24'sd300, 24'sd1000);
    send_centre(24'sd65535, 24'sd65407);
    drain();
  endtask

  // empty area, empty border, small and zero radius, zero sizes
  task automatic test_special_cases;
    set_config(24'd1, 16'd256, 16'd16, 16'd16);
    send_centre(24'sd1000, 24'sd1100);
    drain();
    set_config(24'd0, 16'd0, 16'd16, 16'd16);
    send_centre(24'sd5, 24'sd7);
    send_centre(-24'sd1, 24'sd3);
    drain();
    set_config(24'd2000, 16'd100, 16'd64, 16'd64);
    send_centre(24'sd3000, 24'sd3000);
    send_centre(24'sd50, 24'sd150);
    drain();
    set_config(24'd300, 16'd256, 16'd0, 16'd8);
    send_centre(24'sd512, 24'sd512);
    drain();
    set_config(24'd300, 16'd256, 16'd8, 16'd0);
    send_centre(24'sd512, 24'sd512);
    drain();
  endtask

  // extreme register values
  task automatic test_extremes;
    set_config(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_centre(24'sh7FFFFF, 24'sd0);
    send_centre(24'sd0, 24'sh7FFFFF);
    drain();
    set_config(24'd1, 16'd1, 16'd1, 16'd1);
    send_centre(24'sd0, 24'sd0);
    send_centre(24'sd1, 24'sd0);
    drain();
  endtask

  // random configurations with centres mostly near the grid
  task automatic test_random(input int n_items, input bit pause);
    logic [15:0] s, w, h;
    logic [23:0] r;
    longint      x, y;
    s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
    w = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
    h = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
    r = 24'(longint'(s) * $urandom_range(0, 4) + $urandom_range(0, s));
    set_config(r, s, w, h);
    for (int i = 0; i < n_items; i++) begin
      if (pause && i == n_items / 2) drain();
      if ($urandom_range(0, 4) == 0) begin
        send_centre(24'($urandom), 24'($urandom));
      end else begin
        x = longint'($urandom_range(0, w + 1)) * s - s + $urandom_range(0, 2 * s);
        y = longint'($urandom_range(0, h + 1)) * s - s + $urandom_range(0, 2 * s);
        send_centre(x[23:0], y[23:0]);
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_special_cases();
    test_extremes();
    test_random(35, 1'b1);
    test_random(35, 1'b0);
    send_idle = 49;
    recv_idle = 36;
    test_random(35, 1'b0);
    test_random(35, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    test_random(35, 1'b0);
    test_random(35, 1'b0);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop on hang
  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/drr_pkg.sv
hw/rtl/drr_front.sv
hw/rtl/drr_queue.sv
hw/rtl/drr_back.sv
hw/rtl/disc_region_rasterizer.sv
verif/testbench.sv
